// ===== hdl/iufp_pkg.sv =====
// ============================================================================
// iufp_pkg
// Shared types and constants for the serial IMU frame parser.
// ============================================================================
package iufp_pkg;

    // Frame layout and byte codes.
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_GYRO   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    // Byte positions inside one frame.
    localparam logic [3:0] POS_HUNT     = 4'd0;
    localparam logic [3:0] POS_TYPE     = 4'd1;
    localparam logic [3:0] POS_DATA_LO  = 4'd2;
    localparam logic [3:0] POS_DATA_END = 4'd8;
    localparam logic [3:0] POS_CHECKSUM = 4'd10;

    // Default width of the good-frame counter.
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of the good-frame count that leaves the block.
    localparam int GOOD_WIDTH = 32;

    // Entries in the queue between the parser and the result stage.
    localparam int QUEUE_DEPTH = 2;

    // One decoded frame as it leaves the parser.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_frame_rec;

    // Write side of the queue between parser and result stage.
    typedef struct packed {
        logic       push;
        t_frame_rec rec;
    } t_rec_wr;

    // Read side of the queue.
    typedef struct packed {
        logic       valid;
        t_frame_rec rec;
    } t_rec_rd;

endpackage

// ===== hdl/imu_uart_frame_parser_core.sv =====
// ============================================================================
// imu_uart_frame_parser_core
// Finds 11-byte IMU frames in a received byte stream, checks the checksum
// and delivers kind, three axis counts and a running good-frame count.
// Throughput: one byte per cycle, no bubbles while results are drained.
// Path: a good frame is written into the parser queue, then loads the result
// register when that register is free or being popped.
// Reset: synchronous active-low reset clears parser position, queue and count.
// ============================================================================
module imu_uart_frame_parser_core #(
    parameter int COUNT_WIDTH = iufp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_rx_byte,
    input  logic                              pop,
    output logic                              empty,
    output logic [1:0]                        o_frame_kind,
    output logic signed [15:0]                o_axis_x,
    output logic signed [15:0]                o_axis_y,
    output logic signed [15:0]                o_axis_z,
    output logic [iufp_pkg::GOOD_WIDTH-1:0]   o_good_frames
);
    import iufp_pkg::*;

    t_rec_wr w_wr;
    t_rec_rd w_rd;
    logic    w_accept;
    logic    w_take;

    // A byte transaction completes when the queue has room.
    assign w_accept = push && !full;

    iufp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_wr      (w_wr)
    );

    iufp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_take  (w_take),
        .o_rd    (w_rd),
        .o_full  (full)
    );

    iufp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd          (w_rd),
        .o_take        (w_take),
        .pop           (pop),
        .empty         (empty),
        .o_frame_kind  (o_frame_kind),
        .o_axis_x      (o_axis_x),
        .o_axis_y      (o_axis_y),
        .o_axis_z      (o_axis_z),
        .o_good_frames (o_good_frames)
    );

endmodule

// ===== hdl/iufp_front.sv =====
// ============================================================================
// iufp_front
// Byte parser: hunts for headers, gathers frame bytes, checks the additive
// checksum and hands each good frame to the queue.
// ============================================================================
module iufp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    output iufp_pkg::t_rec_wr  o_wr
);
    import iufp_pkg::*;

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [1:0] r_kind;
    logic [7:0] r_data [2:7];
    logic       w_known;
    logic       w_kind_we;
    logic       w_data_we;
    logic       w_push;

    assign w_known = (i_rx_byte == TYPE_ACCEL) || (i_rx_byte == TYPE_GYRO) ||
                     (i_rx_byte == TYPE_ANGLE);

    // Position and checksum tracking for each accepted byte.
    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        w_kind_we = 1'b0;
        w_data_we = 1'b0;
        w_push    = 1'b0;
        if (i_accept) begin
            priority if (r_pos == POS_HUNT) begin
                if (i_rx_byte == HEADER_BYTE) begin
                    n_pos = POS_TYPE;
                    n_sum = HEADER_BYTE;
                end
            end else if (r_pos == POS_TYPE) begin
                if (w_known) begin
                    w_kind_we = 1'b1;
                    n_sum     = r_sum + i_rx_byte;
                    n_pos     = POS_DATA_LO;
                end else if (i_rx_byte == HEADER_BYTE) begin
                    n_pos = POS_TYPE;
                    n_sum = HEADER_BYTE;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos < POS_CHECKSUM) begin
                w_data_we = (r_pos < POS_DATA_END);
                n_sum     = r_sum + i_rx_byte;
                n_pos     = r_pos + 4'd1;
            end else begin
                // Closing byte: emit only on a matching checksum.
                n_pos  = POS_HUNT;
                w_push = (r_pos == POS_CHECKSUM) && (r_sum == i_rx_byte);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // Frame payload bytes; the kind is stored already decoded.
    always_ff @(posedge i_clk) begin
        if (w_kind_we) begin
            r_kind <= 2'(i_rx_byte - TYPE_ACCEL);
        end
        if (w_data_we) begin
            r_data[r_pos[2:0]] <= i_rx_byte;
        end
    end

    assign o_wr.push       = w_push;
    assign o_wr.rec.kind   = r_kind;
    assign o_wr.rec.axis_x = {r_data[3], r_data[2]};
    assign o_wr.rec.axis_y = {r_data[5], r_data[4]};
    assign o_wr.rec.axis_z = {r_data[7], r_data[6]};

endmodule

// ===== hdl/iufp_queue.sv =====
// ============================================================================
// iufp_queue
// Short queue of decoded frames between the parser and the result stage.
// ============================================================================
module iufp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iufp_pkg::t_rec_wr  i_wr,
    input  logic               i_take,
    output iufp_pkg::t_rec_rd  o_rd,
    output logic               o_full
);
    import iufp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign w_push = i_wr.push && !o_full;
    assign w_pop  = i_take && o_rd.valid;

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 :
                            r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 :
                            r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.rec;
        end
    end

    assign o_rd.valid = (r_count != '0);
    assign o_rd.rec   = r_mem[r_rd_ptr];
    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));

endmodule

// ===== hdl/iufp_back.sv =====
// ============================================================================
// iufp_back
// Result stage: counts good frames and holds the result register.
// ============================================================================
module iufp_back #(
    parameter int COUNT_WIDTH = iufp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iufp_pkg::t_rec_rd                 i_rd,
    output logic                              o_take,
    input  logic                              pop,
    output logic                              empty,
    output logic [1:0]                        o_frame_kind,
    output logic signed [15:0]                o_axis_x,
    output logic signed [15:0]                o_axis_y,
    output logic signed [15:0]                o_axis_z,
    output logic [iufp_pkg::GOOD_WIDTH-1:0]   o_good_frames
);
    import iufp_pkg::*;

    logic                   r_out_valid;
    t_frame_rec             r_out;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [63:0]            w_count_ext;

    // Load the result register when it is free or being drained.
    assign o_take = i_rd.valid && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                r_count     <= r_count + COUNT_WIDTH'(1);
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= i_rd.rec;
        end
    end

    // The counter already includes the frame on display.
    assign w_count_ext   = 64'(r_count);
    assign empty         = !r_out_valid;
    assign o_frame_kind  = r_out.kind;
    assign o_axis_x      = r_out.axis_x;
    assign o_axis_y      = r_out.axis_y;
    assign o_axis_z      = r_out.axis_z;
    assign o_good_frames = w_count_ext[GOOD_WIDTH-1:0];

endmodule
